### hw/rtl/dpd_pkg.sv
// Shared constants and types for the DLE packet deframer.
package dpd_pkg;

   localparam logic [7:0]  DLE_CODE         = 8'h10;
   localparam logic [7:0]  ETX_CODE         = 8'h03;
   localparam logic [11:0] MAX_LENGTH_RESET = 12'd1024;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_END     = 2'd1,
      KIND_DISCARD = 2'd2
   } kind_type;

   // One step of the deframer: whether it gives a result, and that result.
   typedef struct packed {
      logic        has_result;
      kind_type    kind;
      logic [7:0]  data_byte;
      logic [11:0] packet_length;
      logic        terminated;
   } result_type;

endpackage

### hw/rtl/dpd_engine.sv
// Framing state machine: mode and byte count, one item per fire strobe.
module dpd_engine
   import dpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [11:0] max_length,
   input  logic        fire,
   input  logic        is_tick,
   input  logic [7:0]  rx_byte,
   output result_type  result
);

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_DATA   = 2'd1,
      MODE_ESCAPE = 2'd2
   } mode_type;

   mode_type    mode_ff, mode_in;
   logic [11:0] count_ff, count_in;

   always_comb begin
      mode_in              = mode_ff;
      count_in             = count_ff;
      result.has_result    = 1'b0;
      result.kind          = KIND_PAYLOAD;
      result.data_byte     = 8'd0;
      result.packet_length = 12'd0;
      result.terminated    = 1'b0;
      if (is_tick) begin
         if (mode_ff == MODE_DATA || mode_ff == MODE_ESCAPE) begin
            result.has_result    = 1'b1;
            result.kind          = KIND_END;
            result.packet_length = count_ff;
            mode_in              = MODE_IDLE;
            count_in             = 12'd0;
         end
      end else begin
         unique case (mode_ff)
            MODE_DATA: begin
               if (rx_byte == DLE_CODE) begin
                  if (count_ff != 12'd0) begin
                     mode_in = MODE_ESCAPE;
                  end
               end else begin
                  result.has_result = 1'b1;
                  if (count_ff >= max_length) begin
                     result.kind = KIND_DISCARD;
                     mode_in     = MODE_IDLE;
                     count_in    = 12'd0;
                  end else begin
                     result.kind      = KIND_PAYLOAD;
                     result.data_byte = rx_byte;
                     count_in         = count_ff + 12'd1;
                  end
               end
            end
            MODE_ESCAPE: begin
               result.has_result = 1'b1;
               if (rx_byte == DLE_CODE) begin
                  // literal DLE, still subject to the length limit
                  if (count_ff >= max_length) begin
                     result.kind = KIND_DISCARD;
                     mode_in     = MODE_IDLE;
                     count_in    = 12'd0;
                  end else begin
                     result.kind      = KIND_PAYLOAD;
                     result.data_byte = rx_byte;
                     count_in         = count_ff + 12'd1;
                     mode_in          = MODE_DATA;
                  end
               end else if (rx_byte == ETX_CODE) begin
                  result.kind          = KIND_END;
                  result.packet_length = count_ff;
                  result.terminated    = 1'b1;
                  mode_in              = MODE_IDLE;
                  count_in             = 12'd0;
               end else begin
                  // drop the packet; the byte is consumed here and is not examined again as idle
                  result.kind = KIND_DISCARD;
                  mode_in     = MODE_IDLE;
                  count_in    = 12'd0;
               end
            end
            default: begin
               mode_in = MODE_IDLE;
               if (rx_byte == DLE_CODE) begin
                  mode_in  = MODE_DATA;
                  count_in = 12'd0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         count_ff <= 12'd0;
      end else if (fire) begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
      end
   end

endmodule

### hw/rtl/dle_packet_deframer_top.sv
// Top level of the DLE packet deframer: input register, engine, result register.
// Flow: an accepted item waits in the input register, and its result is registered
// in the result register, from which it leaves when rsp_ready is high.
// Throughput: one item per cycle; the framing state updates as an item leaves
// the input register, so only a stalled result register holds the flow.
// Reset (synchronous, active high) empties both registers, returns the mode
// to idle with a zero count and sets max_length to 1024.
module dle_packet_deframer_top
   import dpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_result_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [11:0] rsp_packet_length,
   output logic        rsp_terminated,
   input  logic        csr_write_enable,
   input  logic [11:0] csr_write_data
);

   logic [11:0] max_length_ff;
   logic        in_valid_ff, in_valid_in;
   logic        in_tick_ff;
   logic [7:0]  in_byte_ff;
   logic        out_valid_ff, out_valid_in;
   result_type  out_ff;
   result_type  step_result;
   logic        fire;

   assign fire      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;

   dpd_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .max_length (max_length_ff),
      .fire       (fire),
      .is_tick    (in_tick_ff),
      .rx_byte    (in_byte_ff),
      .result     (step_result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (fire) begin
         out_valid_in = step_result.has_result;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= MAX_LENGTH_RESET;
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_write_enable) begin
            max_length_ff <= csr_write_data;
         end
      end
   end

   // payload registers: input loads on acceptance, result loads on fire
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_tick_ff <= req_type;
         in_byte_ff <= req_rx_byte;
      end
      if (fire) begin
         out_ff <= step_result;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_result_kind   = out_ff.kind;
   assign rsp_data_byte     = out_ff.data_byte;
   assign rsp_packet_length = out_ff.packet_length;
   assign rsp_terminated    = out_ff.terminated;

`ifndef SYNTH
   // Input stalls only when both registers are full and the result is held.
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && out_valid_ff && !rsp_ready))
      else $error("req_ready low without a full, stalled pipeline");

   // A waiting item is neither lost nor altered while the result side stalls.
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !fire) |=> (in_valid_ff && $stable(in_byte_ff)
                                  && $stable(in_tick_ff)))
      else $error("stalled input item changed");

   // Length and terminated flag appear only on an end result.
   a_end_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_kind != KIND_END) |->
         (rsp_packet_length == 12'd0 && !rsp_terminated))
      else $error("length or terminated set on a non-end result");
`endif

endmodule
